### rtl/hrtf_pkg.sv
// shared types and constants for the host route table forwarder
package hrtf_pkg;

	localparam int ROUTE_ENTRIES = 16;
	localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_GATEWAY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MTU_STA = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MTU_AP = 2'd2;

	localparam logic [31:0] MCAST_MASK = 32'hf000_0000;
	localparam logic [31:0] MCAST_BASE = 32'he000_0000;

	localparam logic [2:0] OP_UPDATE = 3'd0;
	localparam logic [2:0] OP_REMOVE = 3'd1;
	localparam logic [2:0] OP_FORWARD = 3'd2;
	localparam logic [2:0] OP_QUERY = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;

	localparam logic [1:0] IF_INVALID = 2'd0;
	localparam logic [1:0] IF_STA = 2'd1;
	localparam logic [1:0] IF_AP = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_IF = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	localparam logic [1:0] ACT_DROP = 2'd0;
	localparam logic [1:0] ACT_SEND = 2'd1;
	localparam logic [1:0] ACT_FRAG = 2'd2;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] dest_addr;
		logic [31:0] next_hop_in;
		logic [1:0]  iface_in;
		logic        from_access_point;
		logic        subnet_broadcast;
		logic [15:0] packet_length;
		logic        dont_fragment;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  forward_action;
		logic        egress_iface;
		logic [31:0] next_hop_out;
		logic        is_member;
	} out_item_t;

	// classified command between front and back
	typedef enum logic [2:0] {
		CMD_UPDATE, CMD_REMOVE, CMD_FORWARD, CMD_QUERY, CMD_CLEAR, CMD_IMMEDIATE
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] dest_addr;
		logic [31:0] next_hop_in;
		logic [1:0]  iface_in;
		logic        from_access_point;
		logic [15:0] packet_length;
		logic        dont_fragment;
		logic [1:0]  imm_status;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_SCAN, BK_FINISH, BK_OUT
	} bk_state_t;

endpackage

### rtl/hrtf_front.sv
// front end: accepts items and classifies them into table jobs
module hrtf_front (
	input  logic              in_valid,
	output logic              in_stall,
	input  hrtf_pkg::in_item_t in_data,
	output logic              job_valid,
	input  logic              job_full,
	output hrtf_pkg::job_t    job
);
	import hrtf_pkg::*;

	logic bcast;

	assign in_stall = job_full;
	assign job_valid = in_valid && !job_full;

	assign bcast = (in_data.dest_addr == 32'hffff_ffff) || (in_data.dest_addr == 32'd0) ||
		in_data.subnet_broadcast || ((in_data.dest_addr & MCAST_MASK) == MCAST_BASE);

	always_comb begin
		job.dest_addr = in_data.dest_addr;
		job.next_hop_in = in_data.next_hop_in;
		job.iface_in = in_data.iface_in;
		job.from_access_point = in_data.from_access_point;
		job.packet_length = in_data.packet_length;
		job.dont_fragment = in_data.dont_fragment;
		job.imm_status = ST_OK;
		job.cmd = CMD_IMMEDIATE;
		unique case (in_data.op)
			OP_UPDATE: begin
				if (in_data.iface_in == IF_STA || in_data.iface_in == IF_AP) begin
					job.cmd = CMD_UPDATE;
				end else begin
					job.imm_status = ST_BAD_IF;
				end
			end
			OP_REMOVE: job.cmd = CMD_REMOVE;
			OP_FORWARD: job.cmd = bcast ? CMD_IMMEDIATE : CMD_FORWARD;
			OP_QUERY: job.cmd = CMD_QUERY;
			OP_CLEAR: job.cmd = CMD_CLEAR;
			default: job.cmd = CMD_IMMEDIATE;
		endcase
	end
endmodule

### rtl/hrtf_queue.sv
// two-entry job queue between front and back
module hrtf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hrtf_pkg::job_t push_data,
	output logic           full,
	output logic           not_empty,
	input  logic           pop,
	output hrtf_pkg::job_t head
);
	import hrtf_pkg::*;

	job_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

### rtl/hrtf_back.sv
// back end: scans the route table and builds one result per job
module hrtf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  hrtf_pkg::job_t     job,
	output logic               job_pop,
	input  logic [31:0]        gateway_q,
	input  logic [15:0]        mtu_sta_q,
	input  logic [15:0]        mtu_ap_q,
	output logic               out_valid,
	input  logic               out_stall,
	output hrtf_pkg::out_item_t out_data
);
	import hrtf_pkg::*;

	logic [31:0] dest_q [ROUTE_ENTRIES];
	logic [31:0] nh_q [ROUTE_ENTRIES];
	logic [1:0]  if_q [ROUTE_ENTRIES];

	bk_state_t   state_q, state_d;
	logic [CNT_W-1:0] k_q;
	logic        eq_hit_q, free_hit_q, vhit_q;
	logic [IDX_W-1:0] eq_idx_q, free_idx_q, vhit_idx_q;
	out_item_t   res_q;
	job_t        job_q;

	logic [IDX_W-1:0] ki;
	logic        cur_eq, cur_valid;
	logic        scan_last;
	logic [31:0] hop;
	logic        egr;
	logic        routed;
	logic [15:0] mtu;
	out_item_t   res_d;

	assign ki = k_q[IDX_W-1:0];
	assign cur_eq = dest_q[ki] == job_q.dest_addr;
	assign cur_valid = (if_q[ki] == IF_STA) || (if_q[ki] == IF_AP);
	assign scan_last = (k_q == CNT_W'(ROUTE_ENTRIES - 1));
	assign out_valid = (state_q == BK_OUT);
	assign out_data = res_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (job_valid) state_d = BK_SCAN;
			BK_SCAN: begin
				if (job_q.cmd == CMD_IMMEDIATE || job_q.cmd == CMD_CLEAR || scan_last) begin
					state_d = BK_FINISH;
				end
			end
			BK_FINISH: state_d = BK_OUT;
			BK_OUT: if (!out_stall) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	assign job_pop = (state_q == BK_IDLE) && job_valid;

	// result from the finished scan
	always_comb begin
		hop = vhit_q ? nh_q[vhit_idx_q] : gateway_q;
		egr = vhit_q && (if_q[vhit_idx_q] == IF_AP);
		routed = vhit_q || job_q.from_access_point;
		mtu = egr ? mtu_ap_q : mtu_sta_q;
		res_d = '0;
		case (job_q.cmd)
			CMD_IMMEDIATE: res_d.status = job_q.imm_status;
			CMD_UPDATE: res_d.status = (eq_hit_q || free_hit_q) ? ST_OK : ST_FULL;
			CMD_REMOVE: res_d.status = eq_hit_q ? ST_OK : ST_NOT_FOUND;
			CMD_QUERY: begin
				res_d.is_member = vhit_q;
				res_d.status = vhit_q ? ST_OK : ST_NOT_FOUND;
			end
			CMD_FORWARD: begin
				if (!routed) begin
					res_d.status = ST_NOT_FOUND;
				end else begin
					res_d.egress_iface = egr;
					res_d.next_hop_out = hop;
					if (mtu != 16'd0 && job_q.packet_length > mtu) begin
						res_d.forward_action = job_q.dont_fragment ? ACT_DROP : ACT_FRAG;
					end else begin
						res_d.forward_action = ACT_SEND;
					end
				end
			end
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			for (int i = 0; i < ROUTE_ENTRIES; i++) begin
				if_q[i] <= IF_INVALID;
				dest_q[i] <= '0;
				nh_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == BK_SCAN && job_q.cmd == CMD_CLEAR) begin
				for (int i = 0; i < ROUTE_ENTRIES; i++) begin
					if_q[i] <= IF_INVALID;
					dest_q[i] <= '0;
					nh_q[i] <= '0;
				end
			end
			if (state_q == BK_FINISH) begin
				if (job_q.cmd == CMD_UPDATE) begin
					if (eq_hit_q) begin
						nh_q[eq_idx_q] <= job_q.next_hop_in;
						if_q[eq_idx_q] <= job_q.iface_in;
					end else if (free_hit_q) begin
						dest_q[free_idx_q] <= job_q.dest_addr;
						nh_q[free_idx_q] <= job_q.next_hop_in;
						if_q[free_idx_q] <= job_q.iface_in;
					end
				end else if (job_q.cmd == CMD_REMOVE && eq_hit_q) begin
					if_q[eq_idx_q] <= IF_INVALID;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
			k_q <= '0;
			eq_hit_q <= 1'b0;
			free_hit_q <= 1'b0;
			vhit_q <= 1'b0;
		end else if (state_q == BK_SCAN) begin
			k_q <= k_q + 1'b1;
			if (cur_eq && !eq_hit_q) begin
				eq_hit_q <= 1'b1;
				eq_idx_q <= ki;
			end
			if (!cur_valid && !free_hit_q) begin
				free_hit_q <= 1'b1;
				free_idx_q <= ki;
			end
			if (cur_eq && cur_valid && !vhit_q) begin
				vhit_q <= 1'b1;
				vhit_idx_q <= ki;
			end
		end
		if (state_q == BK_FINISH) begin
			res_q <= res_d;
		end
	end
endmodule

### rtl/host_route_table_forwarder.sv
// top level of the host route table forwarder
//  channel | signals                      | transfer when
//  in      | in_valid in_stall in_data    | in_valid && !in_stall
//  out     | out_valid out_stall out_data | out_valid && !out_stall
//  cfg     | cfg_we cfg_index cfg_data    | cfg_we
// a table job passes through the back end in order: dispatch, a sequential scan
// of every entry, commit, and a result slot held while out_stall is high
// broadcast, refused and clear items skip the entry scan; clear wipes the table at once
// reset empties the route table and clears the cfg, state and queue pointer registers
// the two-entry job queue lets the front accept up to two jobs while a result waits
module host_route_table_forwarder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  hrtf_pkg::in_item_t    in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output hrtf_pkg::out_item_t   out_data,
	input  logic                  cfg_we,
	input  logic [hrtf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hrtf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hrtf_pkg::*;

	logic [31:0] gateway_q;
	logic [15:0] mtu_sta_q, mtu_ap_q;
	logic        push, full, not_empty, pop;
	job_t        push_job, head_job;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gateway_q <= '0;
			mtu_sta_q <= '0;
			mtu_ap_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GATEWAY: gateway_q <= cfg_data;
				REG_MTU_STA: mtu_sta_q <= cfg_data[15:0];
				REG_MTU_AP: mtu_ap_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	hrtf_front u_front (
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.job_valid(push), .job_full(full), .job(push_job)
	);

	hrtf_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_job), .full(full),
		.not_empty(not_empty), .pop(pop), .head(head_job)
	);

	hrtf_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(not_empty), .job(head_job), .job_pop(pop),
		.gateway_q(gateway_q), .mtu_sta_q(mtu_sta_q), .mtu_ap_q(mtu_ap_q),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);
endmodule
